// File: design/etok_pkg.sv
// Package for the expression tokenizer: item types, token codes, the queued
// command format and the character class helpers.
// No dependencies.
package etok_pkg;

   localparam int unsigned MAX_TOKEN_LEN_DEF = 32;
   // Token lengths are held in six bits, enough for the default buffer length of 32.
   localparam int unsigned LEN_W = 6;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W = 1;
   localparam int unsigned QCNT_W = 2;
   localparam int unsigned KW_LEN = 5;

   localparam logic [3:0] TT_NUMBER   = 4'd0;
   localparam logic [3:0] TT_PRINT    = 4'd1;
   localparam logic [3:0] TT_IDENT    = 4'd2;
   localparam logic [3:0] TT_PLUS     = 4'd3;
   localparam logic [3:0] TT_MINUS    = 4'd4;
   localparam logic [3:0] TT_MULTIPLY = 4'd5;
   localparam logic [3:0] TT_DIVIDE   = 4'd6;
   localparam logic [3:0] TT_LPAREN   = 4'd7;
   localparam logic [3:0] TT_RPAREN   = 4'd8;
   localparam logic [3:0] TT_SEMI     = 4'd9;
   localparam logic [3:0] TT_END      = 4'd10;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD_CHAR = 2'd1;
   localparam logic [1:0] ST_TOO_LONG = 2'd2;

   localparam logic [7:0] CH_NUL        = 8'h00;
   localparam logic [7:0] CH_TAB        = 8'h09;
   localparam logic [7:0] CH_CR         = 8'h0D;
   localparam logic [7:0] CH_SPACE      = 8'h20;
   localparam logic [7:0] CH_LPAREN     = 8'h28;
   localparam logic [7:0] CH_RPAREN     = 8'h29;
   localparam logic [7:0] CH_STAR       = 8'h2A;
   localparam logic [7:0] CH_PLUS       = 8'h2B;
   localparam logic [7:0] CH_MINUS      = 8'h2D;
   localparam logic [7:0] CH_SLASH      = 8'h2F;
   localparam logic [7:0] CH_ZERO       = 8'h30;
   localparam logic [7:0] CH_NINE       = 8'h39;
   localparam logic [7:0] CH_SEMI       = 8'h3B;
   localparam logic [7:0] CH_UPPER_A    = 8'h41;
   localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_LOWER_A    = 8'h61;
   localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
   localparam logic [7:0] CH_P          = 8'h70;
   localparam logic [7:0] CH_R          = 8'h72;
   localparam logic [7:0] CH_I          = 8'h69;
   localparam logic [7:0] CH_N          = 8'h6E;
   localparam logic [7:0] CH_T          = 8'h74;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_NUM,
      MODE_IDENT,
      MODE_SKIP
   } scan_mode_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_LOAD,
      BK_TAIL
   } back_state_type;

   typedef struct packed {
      logic       action;
      logic [7:0] ch;
   } req_type;

   typedef struct packed {
      logic [3:0] token_type;
      logic [7:0] text_char;
      logic       token_last;
      logic       run_last;
      logic [1:0] status;
   } rsp_type;

   // One command per input item that gives results: an optional buffered
   // token to send, then an optional single result.
   typedef struct packed {
      logic             bank;
      logic [LEN_W-1:0] flush_len;
      logic [3:0]       flush_type;
      logic             has_tail;
      logic [3:0]       tail_type;
      logic [7:0]       tail_char;
      logic             tail_last;
      logic [1:0]       tail_status;
   } cmd_type;

   // The back end hands a token buffer bank back once it has read it out.
   typedef struct packed {
      logic valid;
      logic bank;
   } release_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
             ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic logic is_operator(input logic [7:0] c);
      return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
             (c == CH_SLASH) || (c == CH_LPAREN) || (c == CH_RPAREN) ||
             (c == CH_SEMI);
   endfunction

   function automatic logic [3:0] op_token(input logic [7:0] c);
      logic [3:0] t;
      case (c)
         CH_PLUS:   t = TT_PLUS;
         CH_MINUS:  t = TT_MINUS;
         CH_STAR:   t = TT_MULTIPLY;
         CH_SLASH:  t = TT_DIVIDE;
         CH_LPAREN: t = TT_LPAREN;
         CH_RPAREN: t = TT_RPAREN;
         CH_SEMI:   t = TT_SEMI;
         default:   t = TT_NUMBER;
      endcase
      return t;
   endfunction

   // Spelling of the print keyword, one character per position.
   function automatic logic [7:0] kw_char(input logic [2:0] pos);
      logic [7:0] c;
      case (pos)
         3'd0:    c = CH_P;
         3'd1:    c = CH_R;
         3'd2:    c = CH_I;
         3'd3:    c = CH_N;
         3'd4:    c = CH_T;
         default: c = CH_NUL;
      endcase
      return c;
   endfunction

endpackage

// File: design/etok_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module etok_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/etok_cmd_queue.sv
// Short command queue between the tokenizer front and back ends.
// Depends on etok_pkg.
module etok_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  etok_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output etok_pkg::cmd_type pop_data,
   output logic              empty
);
   import etok_pkg::*;

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = entry_ff[rd_ptr_ff];
   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);

endmodule

// File: design/etok_front.sv
// Tokenizer front end: classifies each character, writes token text into
// the buffer RAM and queues one command per item that gives results.
// Depends on etok_pkg.
module etok_front #(
   parameter int unsigned MAX_TOKEN_LEN = etok_pkg::MAX_TOKEN_LEN_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  etok_pkg::req_type                    req_data,
   output logic                                 req_stall,
   input  logic                                 q_full,
   output logic                                 cmd_push,
   output etok_pkg::cmd_type                    cmd_data,
   output logic                                 wr_en,
   output logic [$clog2(2*MAX_TOKEN_LEN)-1:0]   wr_addr,
   output logic [7:0]                           wr_data,
   input  etok_pkg::release_type                bank_release
);
   import etok_pkg::*;

   localparam int unsigned AW = $clog2(2*MAX_TOKEN_LEN);

   scan_mode_type    mode_ff, mode_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             kw_ff, kw_in;
   logic             bank_ff, bank_in;
   logic [1:0]       busy_ff, busy_in;

   logic             accept;
   logic             eol, skip, add_char, pending, flush_first;
   logic             too_long, writes, op_hit, invalid, needs_cmd;
   logic             wbank;
   logic [LEN_W-1:0] base_len;
   logic [7:0]       c;

   assign c        = req_data.ch;
   assign eol      = req_data.action;
   assign skip     = !eol && (mode_ff == MODE_SKIP);
   assign add_char = !eol && !skip &&
                     (is_digit(c) || is_letter(c) ||
                      ((c == CH_UNDERSCORE) && (mode_ff == MODE_IDENT)));
   assign op_hit   = !eol && !skip && !add_char && is_operator(c);
   assign invalid  = !eol && !skip && !add_char && !is_space(c) && !is_operator(c);
   assign pending  = ((mode_ff == MODE_NUM) || (mode_ff == MODE_IDENT)) && (len_ff != '0);

   // A letter right after digits closes the number and opens an identifier.
   assign flush_first = pending &&
                        (eol || (!skip && !add_char) ||
                         (is_letter(c) && (mode_ff == MODE_NUM)));
   assign base_len    = (flush_first || (mode_ff == MODE_IDLE)) ? '0 : len_ff;
   assign too_long    = add_char && (base_len >= LEN_W'(MAX_TOKEN_LEN));
   assign writes      = add_char && !too_long;
   assign wbank       = flush_first ? !bank_ff : bank_ff;
   assign needs_cmd   = eol || flush_first || too_long || op_hit || invalid;

   // Text may not go into a bank whose token the back end has not read yet.
   assign req_stall = (needs_cmd && q_full) || (writes && busy_ff[wbank]);
   assign accept    = req_valid && !req_stall;

   // Next-state logic.
   always_comb begin
      mode_in = mode_ff;
      len_in  = len_ff;
      kw_in   = kw_ff;
      bank_in = bank_ff;
      busy_in = busy_ff;
      if (bank_release.valid) begin
         busy_in[bank_release.bank] = 1'b0;
      end
      if (accept) begin
         if (flush_first) begin
            busy_in[bank_ff] = 1'b1;
            bank_in          = !bank_ff;
         end
         if (eol) begin
            mode_in = MODE_IDLE;
            len_in  = '0;
         end else if (skip) begin
            mode_in = MODE_SKIP;
         end else if (too_long || invalid) begin
            mode_in = MODE_SKIP;
            len_in  = '0;
         end else if (writes) begin
            if (is_letter(c) || (c == CH_UNDERSCORE) || (mode_ff == MODE_IDENT)) begin
               mode_in = MODE_IDENT;
            end else begin
               mode_in = MODE_NUM;
            end
            len_in = base_len + LEN_W'(1);
            kw_in  = ((base_len == '0) || kw_ff) &&
                     (base_len < LEN_W'(KW_LEN)) && (c == kw_char(base_len[2:0]));
         end else begin
            mode_in = MODE_IDLE;
            len_in  = '0;
         end
      end
   end

   // Output logic.
   always_comb begin
      cmd_push = accept && needs_cmd;
      wr_en    = accept && writes;
      wr_data  = c;
      wr_addr  = wbank ? AW'(MAX_TOKEN_LEN) + AW'(base_len) : AW'(base_len);

      cmd_data.bank        = bank_ff;
      cmd_data.flush_len   = flush_first ? len_ff : '0;
      if (mode_ff == MODE_NUM) begin
         cmd_data.flush_type = TT_NUMBER;
      end else if ((len_ff == LEN_W'(KW_LEN)) && kw_ff) begin
         cmd_data.flush_type = TT_PRINT;
      end else begin
         cmd_data.flush_type = TT_IDENT;
      end
      cmd_data.has_tail    = eol || too_long || op_hit || invalid;
      cmd_data.tail_type   = TT_NUMBER;
      cmd_data.tail_char   = CH_NUL;
      cmd_data.tail_last   = 1'b0;
      cmd_data.tail_status = ST_OK;
      if (eol) begin
         cmd_data.tail_type = TT_END;
         cmd_data.tail_last = 1'b1;
      end else if (too_long) begin
         cmd_data.tail_status = ST_TOO_LONG;
      end else if (op_hit) begin
         cmd_data.tail_type = op_token(c);
         cmd_data.tail_char = c;
         cmd_data.tail_last = 1'b1;
      end else if (invalid) begin
         cmd_data.tail_status = ST_BAD_CHAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         len_ff  <= '0;
         kw_ff   <= 1'b0;
         bank_ff <= 1'b0;
         busy_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         len_ff  <= len_in;
         kw_ff   <= kw_in;
         bank_ff <= bank_in;
         busy_ff <= busy_in;
      end
   end

endmodule

// File: design/etok_back.sv
// Tokenizer back end: takes queued commands, reads buffered token text out
// of the RAM and drives the result register.
// Depends on etok_pkg.
module etok_back #(
   parameter int unsigned MAX_TOKEN_LEN = etok_pkg::MAX_TOKEN_LEN_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 q_empty,
   input  etok_pkg::cmd_type                    q_data,
   output logic                                 q_pop,
   output logic                                 rd_en,
   output logic [$clog2(2*MAX_TOKEN_LEN)-1:0]   rd_addr,
   input  logic [7:0]                           rd_data,
   output etok_pkg::release_type                bank_release,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output etok_pkg::rsp_type                    rsp_data
);
   import etok_pkg::*;

   localparam int unsigned AW = $clog2(2*MAX_TOKEN_LEN);

   back_state_type   state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             out_free;
   logic             last_char;
   logic [LEN_W-1:0] idx_next;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign idx_next  = idx_ff + LEN_W'(1);
   assign last_char = (idx_next == cmd_ff.flush_len);

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               state_in = (q_data.flush_len != '0) ? BK_READ : BK_TAIL;
            end
         end
         BK_READ: state_in = BK_LOAD;
         BK_LOAD: begin
            if (out_free) begin
               if (!last_char) begin
                  state_in = BK_READ;
               end else if (cmd_ff.has_tail) begin
                  state_in = BK_TAIL;
               end else begin
                  state_in = BK_IDLE;
               end
            end
         end
         BK_TAIL: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // Output logic.
   always_comb begin
      q_pop              = 1'b0;
      rd_en              = 1'b0;
      rd_addr            = cmd_ff.bank ? AW'(MAX_TOKEN_LEN) + AW'(idx_ff) : AW'(idx_ff);
      bank_release.valid = 1'b0;
      bank_release.bank  = cmd_ff.bank;
      cmd_in             = cmd_ff;
      idx_in             = idx_ff;
      rsp_in             = rsp_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               cmd_in = q_data;
               idx_in = '0;
            end
         end
         BK_READ: rd_en = 1'b1;
         BK_LOAD: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.token_type = cmd_ff.flush_type;
               rsp_in.text_char  = rd_data;
               rsp_in.token_last = last_char;
               rsp_in.run_last   = last_char && !cmd_ff.has_tail;
               rsp_in.status     = ST_OK;
               idx_in            = idx_next;
               // The last character is out of the RAM, so the bank is free again.
               bank_release.valid = last_char;
            end
         end
         BK_TAIL: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.token_type = cmd_ff.tail_type;
               rsp_in.text_char  = cmd_ff.tail_char;
               rsp_in.token_last = cmd_ff.tail_last;
               rsp_in.run_last   = 1'b1;
               rsp_in.status     = cmd_ff.tail_status;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && rsp_stall;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: design/expression_tokenizer.sv
// Expression tokenizer top level: front end, command queue, two-bank token buffer
// RAM and back end. Depends on etok_pkg and all etok_ modules.
// Throughput: one character item per cycle into the front while req_stall is low.
// The back end reads each buffered character out of the registered RAM in a read
// state and then a load state before it reaches the result register.
// Reset clears all control state.
module expression_tokenizer #(
   parameter int unsigned MAX_TOKEN_LEN = etok_pkg::MAX_TOKEN_LEN_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  etok_pkg::req_type req_data,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output etok_pkg::rsp_type rsp_data
);
   import etok_pkg::*;

   localparam int unsigned AW        = $clog2(2*MAX_TOKEN_LEN);
   localparam int unsigned RAM_DEPTH = 2*MAX_TOKEN_LEN;

   logic          q_full, q_empty, q_push, q_pop;
   cmd_type       q_push_data, q_pop_data;
   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0]    wr_data, rd_data;
   release_type   bank_release;

   etok_front #(
      .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_data    (req_data),
      .req_stall   (req_stall),
      .q_full      (q_full),
      .cmd_push    (q_push),
      .cmd_data    (q_push_data),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .bank_release(bank_release)
   );

   etok_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_push_data),
      .full     (q_full),
      .pop      (q_pop),
      .pop_data (q_pop_data),
      .empty    (q_empty)
   );

   etok_ram #(
      .WIDTH(8),
      .DEPTH(RAM_DEPTH)
   ) u_text_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   etok_back #(
      .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_data      (q_pop_data),
      .q_pop       (q_pop),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .bank_release(bank_release),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

// File: tb/expression_tokenizer_checker.sv
`timescale 1ns / 1ps
// Checker for the expression tokenizer: watches both channels, predicts the token
// results of every accepted item and compares them in order. Depends on etok_pkg.
module expression_tokenizer_checker #(
   parameter int unsigned MAX_TOKEN_LEN = etok_pkg::MAX_TOKEN_LEN_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  etok_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  etok_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending
);
   import etok_pkg::*;

   scan_mode_type lex_mode;
   logic [7:0]    token_buf [MAX_TOKEN_LEN];
   int unsigned   token_len;
   rsp_type       expected_tokens [$];
   rsp_type       item_tokens [$];
   int            errors = 0;

   task automatic put_token(input logic [3:0] ttype, input logic [7:0] c,
                            input logic tlast, input logic [1:0] st);
      rsp_type r;
      r.token_type = ttype;
      r.text_char = c;
      r.token_last = tlast;
      r.run_last = 1'b0;
      r.status = st;
      item_tokens.insert(item_tokens.size(), r);
   endtask

   // Sends out the buffered number or identifier, if any, and returns to idle.
   task automatic flush_token();
      logic [3:0] ttype;
      if ((lex_mode == MODE_NUM || lex_mode == MODE_IDENT) && token_len > 0) begin
         if (lex_mode == MODE_NUM)
            ttype = TT_NUMBER;
         else if (token_len == KW_LEN && {token_buf[0], token_buf[1], token_buf[2],
                                          token_buf[3], token_buf[4]} == "print")
            ttype = TT_PRINT;
         else
            ttype = TT_IDENT;
         for (int i = 0; i < token_len; i++)
            put_token(ttype, token_buf[i], (i + 1) == token_len, ST_OK);
      end
      token_len = 0;
      lex_mode = MODE_IDLE;
   endtask

   task automatic abort_line(input logic [1:0] st);
      token_len = 0;
      lex_mode = MODE_SKIP;
      put_token(TT_NUMBER, CH_NUL, 1'b0, st);
   endtask

   task automatic buffer_char(input logic [7:0] c);
      if (token_len >= MAX_TOKEN_LEN) begin
         abort_line(ST_TOO_LONG);
      end else begin
         token_buf[token_len] = c;
         token_len++;
      end
   endtask

   // Token code of a one-character operator; TT_NUMBER means not an operator.
   function automatic logic [3:0] operator_token(input logic [7:0] c);
      case (c)
         CH_PLUS:   return TT_PLUS;
         CH_MINUS:  return TT_MINUS;
         CH_STAR:   return TT_MULTIPLY;
         CH_SLASH:  return TT_DIVIDE;
         CH_LPAREN: return TT_LPAREN;
         CH_RPAREN: return TT_RPAREN;
         CH_SEMI:   return TT_SEMI;
         default:   return TT_NUMBER;
      endcase
   endfunction

   task automatic lex_item(input req_type item);
      logic [7:0] c;
      logic       is_dig;
      logic       is_let;
      logic       is_ws;
      rsp_type    tail;
      c = item.ch;
      is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
      is_let = ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
               ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
      is_ws = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
      item_tokens.delete();
      if (item.action) begin
         flush_token();
         put_token(TT_END, CH_NUL, 1'b1, ST_OK);
      end else if (lex_mode == MODE_SKIP) begin
         // The rest of a failed line gives nothing.
      end else if (is_dig) begin
         if (lex_mode == MODE_IDLE) begin
            lex_mode = MODE_NUM;
            token_len = 0;
         end
         buffer_char(c);
      end else if (is_let) begin
         if (lex_mode == MODE_NUM)
            flush_token();
         if (lex_mode == MODE_IDLE) begin
            lex_mode = MODE_IDENT;
            token_len = 0;
         end
         buffer_char(c);
      end else if (c == CH_UNDERSCORE && lex_mode == MODE_IDENT) begin
         buffer_char(c);
      end else if (is_ws) begin
         flush_token();
      end else if (operator_token(c) != TT_NUMBER) begin
         flush_token();
         put_token(operator_token(c), c, 1'b1, ST_OK);
      end else begin
         flush_token();
         abort_line(ST_BAD_CHAR);
      end
      if (item_tokens.size() > 0) begin
         tail = item_tokens[item_tokens.size() - 1];
         tail.run_last = 1'b1;
         item_tokens[item_tokens.size() - 1] = tail;
      end
      foreach (item_tokens[i])
         expected_tokens.insert(expected_tokens.size(), item_tokens[i]);
   endtask

   function automatic string show(input rsp_type r);
      return $sformatf("type %0d char %02h tlast %b rlast %b status %0d",
                       r.token_type, r.text_char, r.token_last, r.run_last, r.status);
   endfunction

   task automatic check_token(input rsp_type got);
      rsp_type want;
      if (expected_tokens.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("%0t: unexpected result: %s", $time, show(got));
      end else begin
         want = expected_tokens.pop_front();
         if (got.token_type !== want.token_type || got.text_char !== want.text_char ||
             got.token_last !== want.token_last || got.run_last !== want.run_last ||
             got.status !== want.status) begin
            errors++;
            if (errors <= 10)
               $display("%0t: mismatch: expected %s, actual %s",
                        $time, show(want), show(got));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         lex_mode = MODE_IDLE;
         token_len = 0;
         expected_tokens.delete();
      end else begin
         if (req_valid === 1'b1 && req_stall === 1'b0)
            lex_item(req_data);
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
            check_token(rsp_data);
      end
      pending <= expected_tokens.size();
      fail_count <= errors;
   end

endmodule

// File: tb/expression_tokenizer_tb.sv
`timescale 1ns / 1ps
// Top of the expression tokenizer testbench: clock, reset, stimulus and verdict.
// Depends on etok_pkg, expression_tokenizer and expression_tokenizer_checker.
module expression_tokenizer_tb;
   import etok_pkg::*;

   localparam int unsigned TOKEN_MAX = MAX_TOKEN_LEN_DEF;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data = '0;
   logic    req_stall;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   int      fail_count;
   int      pending;
   int      send_gap_pct = 0;
   int      recv_gap_pct = 0;
   logic    hold_off = 1'b0;
   int      items_sent = 0;
   int      base;
   logic [7:0] line_bytes [$];

   expression_tokenizer #(.MAX_TOKEN_LEN(TOKEN_MAX)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   expression_tokenizer_checker #(.MAX_TOKEN_LEN(TOKEN_MAX)) u_chk (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Receiver: random stalls, or a solid hold-off while the block is being filled.
   always @(posedge clock) begin
      if (hold_off)
         rsp_stall <= 1'b1;
      else
         rsp_stall <= ($urandom_range(99) < recv_gap_pct);
   end

   task automatic send_item(input logic act, input logic [7:0] c);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_gap_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= {act, c};
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      items_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_item(1'b0, s[i]);
   endtask

   task automatic end_line();
      send_item(1'b1, 8'($urandom));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
   endtask

   function automatic logic [7:0] any_letter();
      if ($urandom_range(1))
         return CH_LOWER_A + 8'($urandom_range(25));
      return CH_UPPER_A + 8'($urandom_range(25));
   endfunction

   function automatic logic [7:0] any_space();
      int unsigned r;
      r = $urandom_range(5);
      return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
   endfunction

   function automatic logic [7:0] any_operator();
      case ($urandom_range(6))
         0:       return CH_PLUS;
         1:       return CH_MINUS;
         2:       return CH_STAR;
         3:       return CH_SLASH;
         4:       return CH_LPAREN;
         5:       return CH_RPAREN;
         default: return CH_SEMI;
      endcase
   endfunction

   task automatic add_byte(input logic [7:0] b);
      line_bytes.insert(line_bytes.size(), b);
   endtask

   task automatic add_number(input int n);
      repeat (n) add_byte(CH_ZERO + 8'($urandom_range(9)));
   endtask

   task automatic add_ident(input int n);
      int unsigned r;
      add_byte(any_letter());
      repeat (n - 1) begin
         r = $urandom_range(9);
         if (r < 6)
            add_byte(any_letter());
         else if (r < 9)
            add_byte(CH_ZERO + 8'($urandom_range(9)));
         else
            add_byte(CH_UNDERSCORE);
      end
   endtask

   // Most tokens are short; now and then one sits around the buffer limit.
   function automatic int token_size();
      if ($urandom_range(99) < 4)
         return $urandom_range(TOKEN_MAX + 2, TOKEN_MAX - 2);
      return $urandom_range(5, 1);
   endfunction

   task automatic flush_line();
      foreach (line_bytes[i])
         send_item(1'b0, line_bytes[i]);
      line_bytes.delete();
      end_line();
   endtask

   // A well-formed line with random content, and a little noise now and then.
   task automatic random_line();
      int unsigned r;
      repeat ($urandom_range(8, 1)) begin
         r = $urandom_range(99);
         if (r < 30) begin
            add_number(token_size());
         end else if (r < 52) begin
            add_ident(token_size());
         end else if (r < 60) begin
            add_byte(CH_P);
            add_byte(CH_R);
            add_byte(CH_I);
            add_byte(CH_N);
            add_byte(CH_T);
         end else if (r < 85) begin
            add_byte(any_operator());
         end else if (r < 92) begin
            repeat ($urandom_range(3, 1)) add_byte(any_space());
         end else begin
            add_byte(8'($urandom));
         end
         if ($urandom_range(99) < 60)
            add_byte(any_space());
      end
      flush_line();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      send_gap_pct = 11;
      recv_gap_pct <= 83;

      // Keyword, all operators, underscore, tab, a letter right after digits.
      send_text("print\t(a_1*9z) -/+;");
      end_line();
      // A number cut off by a bad byte; the all-ones byte then falls in skip mode.
      send_item(1'b0, CH_NINE);
      send_item(1'b0, CH_NUL);
      send_item(1'b0, 8'hFF);
      send_item(1'b1, 8'hFF);
      send_item(1'b1, CH_NUL);
      wait_drained();

      // A token of exactly the buffer size, then one a character too long.
      add_ident(TOKEN_MAX);
      add_byte(any_operator());
      add_number(TOKEN_MAX + 1);
      flush_line();

      base = items_sent;
      while (items_sent < base + 60)
         random_line();
      wait_drained();

      send_gap_pct = 83;
      recv_gap_pct <= 11;
      while (items_sent < base + 120)
         random_line();
      wait_drained();

      send_gap_pct = 0;
      recv_gap_pct <= 0;
      fork
         begin
            hold_off <= 1'b1;
            repeat (300) @(posedge clock);
            hold_off <= 1'b0;
         end
         begin
            repeat (3) random_line();
         end
      join
      wait_drained();
      while (items_sent < base + 190)
         random_line();

      wait_drained();
      repeat (40) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
